// ===== hdl/assert_macros.svh =====
// Assertion helpers for the RTL, used by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CCL_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define CCL_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define CCL_ASSERT(lbl, clk, rst_n, prop)
`define CCL_ASSERT_NR(lbl, clk, prop)
`endif
`endif

// ===== hdl/ccl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ccl_pkg;
  localparam int ADDR_W = 10;
  localparam int DATA_W = 32;
  localparam int OP_W = 2;
  localparam int MODE_W = 2;
  localparam int STAT_W = 3;

  localparam logic [OP_W-1:0] OP_IDLE  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
  localparam logic [OP_W-1:0] OP_STORE = 2'd2;
  localparam logic [OP_W-1:0] OP_RSVD  = 2'd3;  // unused code, acts as idle

  localparam logic [MODE_W-1:0] MODE_DM = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FA = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SA = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SA_ALT = 2'd3;  // acts as set associative
  localparam logic [MODE_W-1:0] MODE_RESET = MODE_SA;

  localparam logic [STAT_W-1:0] WAIT_START = 3'd4;

  localparam int NUM_LINES_DEF = 16;
  localparam int NUM_WAYS_DEF = 4;
  localparam int MEM_WORDS_DEF = 1024;

  typedef struct packed {
    logic              fire;
    logic              is_load;
    logic              is_store;
    logic [MODE_W-1:0] mode;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] din;
    logic [DATA_W-1:0] mem_data;
  } ccl_cmd_t;

  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] data;
  } ccl_res_t;
endpackage
`default_nettype wire

// ===== hdl/ccl_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ccl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ===== hdl/ccl_lines.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ccl_lines #(
  parameter int NUM_LINES = ccl_pkg::NUM_LINES_DEF,
  parameter int NUM_WAYS  = ccl_pkg::NUM_WAYS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ccl_pkg::ccl_cmd_t  cmd,
  output ccl_pkg::ccl_res_t       res
);
  import ccl_pkg::*;

  localparam int LW = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
  localparam int NS = ((NUM_LINES / NUM_WAYS) > 0) ? (NUM_LINES / NUM_WAYS) : 1;
  localparam int SW = (NS > 1) ? $clog2(NS) : 1;
  localparam int LNS = $clog2(NS);
  localparam int CW = $clog2(NUM_LINES + 1);

  logic              valid_r [NUM_LINES];
  logic [ADDR_W-1:0] tag_r   [NUM_LINES];
  logic [DATA_W-1:0] data_r  [NUM_LINES];
  logic [LW-1:0]     rank_r  [NUM_LINES];

  logic              dm, fa;
  logic [ADDR_W-1:0] key;
  logic [SW-1:0]     set_idx;
  logic [NUM_LINES-1:0] grp;
  logic              hit, has_free, has_r0, has_base;
  logic [LW-1:0]     hit_idx, free_idx, r0_idx, base_idx, victim, sel;
  logic [CW-1:0]     n;
  logic [LW-1:0]     rank_sel;
  logic              touch_ok, install, do_touch;

  always_comb begin
    dm = (cmd.mode == MODE_DM);
    fa = (cmd.mode == MODE_FA);
    set_idx = SW'(cmd.addr) & SW'(NS - 1);
    if (dm) begin
      key = ADDR_W'(cmd.addr >> LW);
    end else if (fa) begin
      key = cmd.addr;
    end else begin
      key = ADDR_W'(cmd.addr >> LNS);
    end
    for (int i = 0; i < NUM_LINES; i++) begin
      if (dm) begin
        grp[i] = (LW'(cmd.addr) == LW'(i));
      end else if (fa) begin
        grp[i] = 1'b1;
      end else begin
        grp[i] = (set_idx == SW'(i / NUM_WAYS));
      end
    end
    hit = 1'b0; has_free = 1'b0; has_r0 = 1'b0; has_base = 1'b0;
    hit_idx = '0; free_idx = '0; r0_idx = '0; base_idx = '0;
    n = '0;
    // first-match priority searches over the group
    for (int i = 0; i < NUM_LINES; i++) begin
      if (grp[i]) begin
        if (!has_base) begin
          has_base = 1'b1;
          base_idx = LW'(i);
        end
        if (valid_r[i] && tag_r[i] == key && !hit) begin
          hit = 1'b1;
          hit_idx = LW'(i);
        end
        if (!valid_r[i] && !has_free) begin
          has_free = 1'b1;
          free_idx = LW'(i);
        end
        if (rank_r[i] == '0 && !has_r0) begin
          has_r0 = 1'b1;
          r0_idx = LW'(i);
        end
        if (valid_r[i]) begin
          n = n + CW'(1);
        end
      end
    end
    if (dm || !(has_free || has_r0)) begin
      victim = base_idx;
    end else if (has_free) begin
      victim = free_idx;
    end else begin
      victim = r0_idx;
    end
    sel = hit ? hit_idx : victim;
    rank_sel = rank_r[sel];
    touch_ok = (n != '0) && (CW'(rank_sel) < CW'(n - CW'(1)));
    install = cmd.fire && cmd.is_load && !hit;
    do_touch = cmd.fire && !dm && touch_ok && (hit || (install && valid_r[sel]));
    res.hit = hit;
    res.data = data_r[hit_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LINES; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else if (install) begin
      valid_r[sel] <= 1'b1;
    end
  end

  // ranks start at zero so lines filled in direct mode rank defined later
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LINES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      if (do_touch) begin
        for (int i = 0; i < NUM_LINES; i++) begin
          if (LW'(i) == sel) begin
            rank_r[i] <= LW'(n - CW'(1));
          end else if (grp[i] && valid_r[i] && rank_r[i] > rank_sel) begin
            rank_r[i] <= rank_r[i] - LW'(1);
          end
        end
      end
      if (install && !dm && !valid_r[sel]) begin
        rank_r[sel] <= LW'(n);  // youngest among the valid lines
      end
    end
  end

  always_ff @(posedge clk) begin
    if (install) begin
      tag_r[sel]  <= key;
      data_r[sel] <= cmd.mem_data;
    end
    if (cmd.fire && cmd.is_store && hit) begin
      data_r[sel] <= cmd.din;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/cache_controller_lru_write_through_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Write-through, no-write-allocate cache with LRU replacement in front of a
// MEM_WORDS-word main memory. After reset the block sweeps main memory to zero,
// one word a cycle with in_ready low. Accepting a request in S_IDLE issues the
// main memory read; S_EXE, held until the result slot is free, then looks up
// the line store, updates it and registers the result; no new request is
// accepted until then. A load miss starts a four-request wait: the following
// three requests only return a countdown status, the fourth returns the memory
// word at its address. cfg_we writes cache_mode (0 direct, 1 fully, 2/3 set
// associative); the user must do so only while idle, the block does not enforce
// it. NUM_LINES, NUM_WAYS and MEM_WORDS are expected to be powers of two.
module cache_controller_lru_write_through_top #(
  parameter int NUM_LINES = ccl_pkg::NUM_LINES_DEF,
  parameter int NUM_WAYS  = ccl_pkg::NUM_WAYS_DEF,
  parameter int MEM_WORDS = ccl_pkg::MEM_WORDS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [ccl_pkg::MODE_W-1:0]  cfg_wdata,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [ccl_pkg::OP_W-1:0]    in_operation,
  input  wire logic [ccl_pkg::ADDR_W-1:0]  in_address,
  input  wire logic [ccl_pkg::DATA_W-1:0]  in_data_in,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [ccl_pkg::DATA_W-1:0]       out_data_out,
  output logic [ccl_pkg::STAT_W-1:0]       out_status,
  output logic                             out_hit,
  output logic [31:0]                      out_miss_count
);
  import ccl_pkg::*;

  localparam int AW = $clog2(MEM_WORDS);
  localparam logic [1:0] S_CLR = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_EXE = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [AW-1:0]     clr_cnt_r;
  logic [MODE_W-1:0] mode_r;
  logic [OP_W-1:0]   op_r;
  logic [ADDR_W-1:0] addr_r;
  logic [DATA_W-1:0] din_r;
  logic [STAT_W-1:0] wait_r, wait_nxt;
  logic [31:0]       miss_r, miss_nxt;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_data_r, dout;
  logic [STAT_W-1:0] out_status_r;
  logic              out_hit_r, hit_o;
  logic [31:0]       out_miss_r;

  logic              accept, exec, is_load, is_store, active;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata, ram_q;
  ccl_cmd_t          cmd;
  ccl_res_t          res;

  assign in_ready = (state_r == S_IDLE);
  assign accept = in_valid && in_ready;
  assign exec = (state_r == S_EXE) && (!out_valid_r || out_ready);
  assign is_load = (op_r == OP_LOAD);
  assign is_store = (op_r == OP_STORE);
  // cache work only for loads and stores when not in a miss wait
  assign active = (wait_r == '0) && (is_load || is_store);

  always_comb begin
    cmd.fire = exec && active;
    cmd.is_load = is_load;
    cmd.is_store = is_store;
    cmd.mode = mode_r;
    cmd.addr = addr_r;
    cmd.din = din_r;
    cmd.mem_data = ram_q;
  end

  ccl_lines #(.NUM_LINES(NUM_LINES), .NUM_WAYS(NUM_WAYS)) u_lines (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .res(res)
  );

  // memory write port: zero sweep after reset, else write-through stores
  always_comb begin
    if (state_r == S_CLR) begin
      ram_we = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = '0;
    end else begin
      ram_we = exec && active && is_store;
      ram_waddr = AW'(addr_r);
      ram_wdata = din_r;
    end
  end

  ccl_ram #(.WIDTH(DATA_W), .DEPTH(MEM_WORDS)) u_mem (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .re(accept), .raddr(AW'(in_address)), .rdata(ram_q)
  );

  always_comb begin
    wait_nxt = wait_r;
    miss_nxt = miss_r;
    dout = din_r;
    hit_o = 1'b0;
    if (wait_r >= STAT_W'(2)) begin
      wait_nxt = wait_r - STAT_W'(1);
    end else if (wait_r == STAT_W'(1)) begin
      dout = ram_q;
      wait_nxt = '0;
    end else if (is_load) begin
      hit_o = res.hit;
      if (res.hit) begin
        dout = res.data;
      end else begin
        dout = ram_q;
        miss_nxt = miss_r + 32'd1;
        wait_nxt = WAIT_START;
      end
    end else if (is_store) begin
      hit_o = res.hit;
      dout = '0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR: begin
        if (clr_cnt_r == AW'(MEM_WORDS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_nxt = S_EXE;
      end
      S_EXE: begin
        if (exec) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_cnt_r <= '0;
      mode_r <= MODE_RESET;
      wait_r <= '0;
      miss_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLR) clr_cnt_r <= clr_cnt_r + AW'(1);
      if (cfg_we) mode_r <= cfg_wdata;
      if (exec) begin
        wait_r <= wait_nxt;
        miss_r <= miss_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= in_operation;
      addr_r <= in_address;
      din_r <= in_data_in;
    end
    if (exec) begin
      out_data_r <= dout;
      out_status_r <= wait_nxt;
      out_hit_r <= hit_o;
      out_miss_r <= miss_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data_out = out_data_r;
  assign out_status = out_status_r;
  assign out_hit = out_hit_r;
  assign out_miss_count = out_miss_r;

  `CCL_ASSERT(a_accept_exe, clk, rst_n, accept |=> (state_r == S_EXE))
  `CCL_ASSERT(a_exec_out, clk, rst_n, exec |=> out_valid_r)
  `CCL_ASSERT(a_wait_max, clk, rst_n, wait_r <= WAIT_START)
  `CCL_ASSERT(a_miss_step, clk, rst_n,
    (miss_r == $past(miss_r)) || (miss_r == $past(miss_r) + 32'd1))
  `CCL_ASSERT_NR(a_clr_block, clk, (state_r == S_CLR) |-> !in_ready)
endmodule
`default_nettype wire

// ===== tb/sv/cache_checker.sv =====
`timescale 1ns / 1ps
module cache_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ccl_pkg::MODE_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [ccl_pkg::OP_W-1:0]      in_operation,
  input  logic [ccl_pkg::ADDR_W-1:0]    in_address,
  input  logic [ccl_pkg::DATA_W-1:0]    in_data_in,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [ccl_pkg::DATA_W-1:0]    out_data_out,
  input  logic [ccl_pkg::STAT_W-1:0]    out_status,
  input  logic                          out_hit,
  input  logic [31:0]                   out_miss_count,
  output int                            fail_count,
  output int                            pending,
  output int                            hits_seen,
  output int                            results_seen
);
  import ccl_pkg::*;
  localparam int LINES = 16;
  localparam int WAYS = 4;
  localparam int SETS = LINES / WAYS;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [STAT_W-1:0] status;
    logic              hit;
    logic [31:0]       misses;
  } cache_resp_t;

  logic              v_q [LINES];
  logic [9:0]        tag_q [LINES];
  logic [DATA_W-1:0] dat_q [LINES];
  int unsigned       rank_q [LINES];
  logic [DATA_W-1:0] mem_q [1024];
  int unsigned       wait_q;
  logic [31:0]       miss_q;
  logic [MODE_W-1:0] mode_q;
  cache_resp_t       expected_resps[$];

  function automatic int unsigned live_in(int unsigned b, int unsigned n);
    int unsigned c;
    c = 0;
    for (int unsigned i = b; i < b + n; i++) if (v_q[i]) c++;
    return c;
  endfunction

  function automatic void promote(int unsigned b, int unsigned n, int unsigned s);
    int unsigned c, old;
    c = live_in(b, n);
    if (c == 0 || rank_q[s] >= c - 1) return;
    old = rank_q[s];
    rank_q[s] = c - 1;
    for (int unsigned i = b; i < b + n; i++)
      if (i != s && v_q[i] && rank_q[i] > 0 && rank_q[i] > old) rank_q[i]--;
  endfunction

  function automatic cache_resp_t predict_access(logic [OP_W-1:0] op, logic [9:0] a,
                                                 logic [DATA_W-1:0] d);
    cache_resp_t r;
    int unsigned b, n, s;
    logic [9:0] t;
    int ln;
    logic dm, found;
    r.data = d;
    r.hit = 1'b0;
    if (wait_q >= 2) begin
      wait_q--;
    end else if (wait_q == 1) begin
      r.data = mem_q[a];
      wait_q = 0;
    end else if (op == OP_LOAD || op == OP_STORE) begin
      dm = (mode_q == MODE_DM);
      if (dm) begin
        b = a % LINES; n = 1; t = a / LINES;
      end else if (mode_q == MODE_FA) begin
        b = 0; n = LINES; t = a;
      end else begin
        b = (a % SETS) * WAYS; n = WAYS; t = a / SETS;
      end
      ln = -1;
      for (int unsigned i = b; i < b + n; i++)
        if (ln < 0 && v_q[i] && tag_q[i] == t) ln = i;
      if (ln >= 0) begin
        r.hit = 1'b1;
        if (!dm) promote(b, n, ln);
      end
      if (op == OP_LOAD) begin
        if (ln >= 0) begin
          r.data = dat_q[ln];
        end else begin
          r.data = mem_q[a];
          s = b;
          if (!dm) begin
            found = 1'b0;
            for (int unsigned i = b; i < b + n; i++)
              if (!found && !v_q[i]) begin s = i; found = 1'b1; end
            for (int unsigned i = b; i < b + n; i++)
              if (!found && rank_q[i] == 0) begin s = i; found = 1'b1; end
            if (!v_q[s]) rank_q[s] = live_in(b, n);
            else promote(b, n, s);
          end
          tag_q[s] = t;
          dat_q[s] = r.data;
          v_q[s] = 1'b1;
          miss_q++;
          wait_q = WAIT_START;
        end
      end else begin
        if (ln >= 0) dat_q[ln] = d;
        mem_q[a] = d;
        r.data = '0;
      end
    end
    r.status = wait_q[STAT_W-1:0];
    r.misses = miss_q;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    cache_resp_t e;
    if (!rst_n) begin
      for (int i = 0; i < LINES; i++) begin
        v_q[i] = 1'b0; tag_q[i] = '0; dat_q[i] = '0; rank_q[i] = 0;
      end
      for (int i = 0; i < 1024; i++) mem_q[i] = '0;
      wait_q = 0;
      miss_q = '0;
      mode_q = MODE_RESET;
      fail_count = 0;
      hits_seen = 0;
      results_seen = 0;
      expected_resps.delete();
    end else begin
      if (cfg_we) mode_q = cfg_wdata;
      if (out_valid && out_ready) begin
        results_seen++;
        if (out_hit) hits_seen++;
        if (expected_resps.size() == 0) begin
          $display("%0t unexpected response", $realtime);
          fail_count++;
        end else begin
          e = expected_resps.pop_front();
          if (out_data_out !== e.data) report_mismatch("data_out", out_data_out, e.data);
          if (out_status !== e.status) report_mismatch("status", out_status, e.status);
          if (out_hit !== e.hit) report_mismatch("hit", out_hit, e.hit);
          if (out_miss_count !== e.misses)
            report_mismatch("miss_count", out_miss_count, e.misses);
        end
      end
      if (in_valid && in_ready)
        expected_resps.push_back(predict_access(in_operation, in_address, in_data_in));
    end
    pending = expected_resps.size();
  end
endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import ccl_pkg::*;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [MODE_W-1:0] cfg_wdata = MODE_RESET;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [OP_W-1:0]   in_operation = OP_IDLE;
  logic [ADDR_W-1:0] in_address = '0;
  logic [DATA_W-1:0] in_data_in = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [DATA_W-1:0] out_data_out;
  logic [STAT_W-1:0] out_status;
  logic              out_hit;
  logic [31:0]       out_miss_count;
  int                fail_count, pending, hits_seen, results_seen;
  int                cycle_count = 0;
  int                requests_sent = 0;

  localparam int CYCLE_LIMIT = 400000;

  always #5 clk = ~clk;

  cache_controller_lru_write_through_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_operation(in_operation), .in_address(in_address), .in_data_in(in_data_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_data_out(out_data_out), .out_status(out_status),
    .out_hit(out_hit), .out_miss_count(out_miss_count)
  );

  cache_checker i_checker (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_operation(in_operation),
    .in_address(in_address), .in_data_in(in_data_in),
    .out_valid(out_valid), .out_ready(out_ready), .out_data_out(out_data_out),
    .out_status(out_status), .out_hit(out_hit), .out_miss_count(out_miss_count),
    .fail_count(fail_count), .pending(pending),
    .hits_seen(hits_seen), .results_seen(results_seen)
  );

  // Watchdog: fails the run at CYCLE_LIMIT, covering the reset sweep, requests and stalls.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver stall pattern: stretches of always-ready, light, heavy and periodic stalls.
  always @(negedge clk) begin
    case ((cycle_count / 300) % 4)
      0: begin
        out_ready <= 1'b1;
      end
      1: begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
      2: begin
        out_ready <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        out_ready <= ((cycle_count % 7) < 4);
      end
    endcase
  end

  // Present one request and hold it until accepted. Bursts have no gap.
  task automatic send_request(logic [OP_W-1:0] op, logic [ADDR_W-1:0] a,
                              logic [DATA_W-1:0] d);
    in_valid <= 1'b1;
    in_operation <= op;
    in_address <= a;
    in_data_in <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    requests_sent++;
  endtask

  task automatic go_idle(int n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Drain every pending response, then let the pipeline settle before config.
  task automatic drain_then_cfg(logic [MODE_W-1:0] m);
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random request: mostly loads/stores on a small address pool so lines
  // get reused and evicted; a few idles, op 3 and full-range addresses.
  task automatic random_request();
    logic [OP_W-1:0] op;
    logic [ADDR_W-1:0] a;
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 9) op = OP_LOAD;
    else if (sel < 16) op = OP_STORE;
    else if (sel < 18) op = OP_IDLE;
    else op = OP_RSVD;
    if ($urandom_range(0, 4) == 0) a = ADDR_W'($urandom_range(0, 1023));
    else a = ADDR_W'({$urandom_range(0, 3), 4'b0} | $urandom_range(0, 15));
    send_request(op, a, $urandom());
  endtask

  task automatic random_phase(int count);
    int burst;
    while (count > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && count > 0) begin
        random_request();
        burst--;
        count--;
      end
      if ($urandom_range(0, 2) != 0) go_idle($urandom_range(1, 6));
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extremes of data and address, every op, miss-wait sequence,
    // store hit update, op 3 while ready.
    send_request(OP_LOAD, 10'd0, 32'h0);
    send_request(OP_IDLE, 10'd5, 32'h7fffffff);
    send_request(OP_STORE, 10'd3, 32'h80000000);
    send_request(OP_LOAD, 10'd1023, 32'hffffffff);
    send_request(OP_LOAD, 10'd0, 32'h12345678);
    send_request(OP_STORE, 10'd0, 32'hffffffff);
    send_request(OP_LOAD, 10'd0, 32'h0);
    send_request(OP_STORE, 10'd1023, 32'h7fffffff);
    send_request(OP_LOAD, 10'd1023, 32'h0);
    send_request(OP_RSVD, 10'd512, 32'haaaa5555);
    send_request(OP_IDLE, 10'd0, 32'h5555aaaa);
    // Fill one set past its ways to force LRU eviction.
    for (int i = 0; i < 6; i++) begin
      send_request(OP_LOAD, 10'(i * 4 + 1), 32'h0);
      repeat (4) send_request(OP_IDLE, 10'(i * 4 + 1), 32'h0);
    end
    send_request(OP_LOAD, 10'd5, 32'h0);

    random_phase(130);
    drain_then_cfg(MODE_DM);
    random_phase(130);
    drain_then_cfg(MODE_FA);
    random_phase(130);
    // Hold the sender until everything has come back.
    drain_then_cfg(MODE_SA_ALT);
    random_phase(120);
    drain_then_cfg(MODE_SA);
    random_phase(120);

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("requests sent %0d, responses checked %0d, hits %0d, over all four modes",
             requests_sent, results_seen, hits_seen);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+hdl
hdl/ccl_pkg.sv
hdl/ccl_ram.sv
hdl/ccl_lines.sv
hdl/cache_controller_lru_write_through_top.sv
tb/sv/cache_checker.sv
tb/sv/tb.sv
